FILE: rtl/rcpw_pkg.sv
// ----------------------------------------------------------------------------
// RTCP compound packet walker package
// Shared widths, codes and types of the walker core.
// ----------------------------------------------------------------------------
package rcpw_pkg;

  localparam int unsigned WordW     = 32;
  localparam int unsigned TypeW     = 8;
  localparam int unsigned CountW    = 5;
  localparam int unsigned LenFieldW = 16;
  localparam int unsigned LenW      = 17;
  localparam int unsigned TotalW    = 16;
  localparam int unsigned StatusW   = 2;

  localparam logic [1:0]        RtcpVersion = 2'd2;
  localparam logic [TotalW-1:0] TotalMax    = 16'hFFFF;

  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = 2;
  localparam int unsigned QCntW  = 3;

  typedef enum logic [2:0] {
    PH_HEADER = 3'b001,
    PH_BODY   = 3'b010,
    PH_SKIP   = 3'b100
  } rcpw_phase_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK       = 2'd0,
    ST_BAD_VER  = 2'd1,
    ST_BAD_TYPE = 2'd2,
    ST_TRUNC    = 2'd3
  } rcpw_status_e;

  typedef enum logic {
    KIND_RECORD  = 1'b0,
    KIND_SUMMARY = 1'b1
  } rcpw_kind_e;

  typedef struct packed {
    rcpw_kind_e        kind;
    logic [TypeW-1:0]  packet_type;
    logic [CountW-1:0] item_count;
    logic              padding;
    logic [LenW-1:0]   length_words;
    logic [TotalW-1:0] packet_total;
    rcpw_status_e      status;
    logic              last_result;
  } rcpw_result_t;

  typedef struct packed {
    logic [1:0]   num;
    rcpw_result_t first;
    rcpw_result_t second;
  } rcpw_push_t;

endpackage

FILE: rtl/rcpw_in_if.sv
// ----------------------------------------------------------------------------
// Walker input channel
// Valid/ready channel carrying one buffer word and its end flag.
// ----------------------------------------------------------------------------
interface rcpw_in_if
  import rcpw_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [WordW-1:0] word;
  logic             last_word;

  modport source (output valid, output word, output last_word, input ready);
  modport sink   (input valid, input word, input last_word, output ready);
endinterface

FILE: rtl/rcpw_out_if.sv
// ----------------------------------------------------------------------------
// Walker result channel
// Valid/ready channel carrying one packet record or buffer summary.
// ----------------------------------------------------------------------------
interface rcpw_out_if
  import rcpw_pkg::*;
();
  logic               valid;
  logic               ready;
  logic               kind;
  logic [TypeW-1:0]   packet_type;
  logic [CountW-1:0]  item_count;
  logic               padding;
  logic [LenW-1:0]    length_words;
  logic [TotalW-1:0]  packet_total;
  logic [StatusW-1:0] status;
  logic               last_result;

  modport source (
    output valid, output kind, output packet_type, output item_count,
    output padding, output length_words, output packet_total, output status,
    output last_result, input ready
  );
  modport sink (
    input valid, input kind, input packet_type, input item_count,
    input padding, input length_words, input packet_total, input status,
    input last_result, output ready
  );
endinterface

FILE: rtl/rcpw_walker.sv
// ----------------------------------------------------------------------------
// Walker step logic
// Header checks, packet tracking and record/summary generation per word.
// ----------------------------------------------------------------------------
module rcpw_walker
  import rcpw_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          room_i,
  rcpw_in_if.sink       in_i,
  output rcpw_push_t    push_o
);

  rcpw_phase_e          phase_q, phase_d;
  logic [LenFieldW-1:0] left_q, left_d;
  logic [TypeW-1:0]     type_q, type_d;
  logic [CountW-1:0]    cnt_q, cnt_d;
  logic                 pad_q, pad_d;
  logic [LenW-1:0]      len_q, len_d;
  logic [TotalW-1:0]    seen_q, seen_d;
  rcpw_status_e         stop_q, stop_d;

  logic         accept;
  logic         fin;
  rcpw_result_t rec;
  rcpw_result_t summ;

  assign in_i.ready = room_i;
  assign accept     = in_i.valid & in_i.ready;

  always_comb begin
    phase_d = phase_q;
    left_d  = left_q;
    type_d  = type_q;
    cnt_d   = cnt_q;
    pad_d   = pad_q;
    len_d   = len_q;
    seen_d  = seen_q;
    stop_d  = stop_q;
    fin     = 1'b0;
    rec     = '0;
    summ    = '0;
    push_o  = '0;

    if (accept) begin
      case (phase_q)
        PH_HEADER: begin
          if (in_i.word[31:30] != RtcpVersion) begin
            stop_d  = ST_BAD_VER;
            phase_d = PH_SKIP;
          end else if (!in_i.word[23]) begin
            stop_d  = ST_BAD_TYPE;
            phase_d = PH_SKIP;
          end else begin
            pad_d  = in_i.word[29];
            cnt_d  = in_i.word[28:24];
            type_d = in_i.word[23:16];
            left_d = in_i.word[15:0];
            len_d  = {1'b0, in_i.word[15:0]} + LenW'(1);
            if (in_i.word[15:0] == '0) begin
              fin = 1'b1;
            end else begin
              phase_d = PH_BODY;
            end
          end
        end
        PH_BODY: begin
          left_d = left_q - LenFieldW'(1);
          if (left_d == '0) begin
            fin = 1'b1;
          end
        end
        default: ;
      endcase

      if (fin) begin
        if (seen_q != TotalMax) begin
          seen_d = seen_q + TotalW'(1);
        end
        phase_d          = PH_HEADER;
        rec.kind         = KIND_RECORD;
        rec.packet_type  = type_d;
        rec.item_count   = cnt_d;
        rec.padding      = pad_d;
        rec.length_words = len_d;
        rec.packet_total = seen_d;
        rec.status       = ST_OK;
        rec.last_result  = !in_i.last_word;
      end

      summ.kind         = KIND_SUMMARY;
      summ.packet_total = seen_d;
      summ.status       = (phase_d == PH_BODY && stop_d == ST_OK) ? ST_TRUNC : stop_d;
      summ.last_result  = 1'b1;

      if (fin) begin
        push_o.first  = rec;
        push_o.second = summ;
        push_o.num    = in_i.last_word ? 2'd2 : 2'd1;
      end else if (in_i.last_word) begin
        push_o.first = summ;
        push_o.num   = 2'd1;
      end

      if (in_i.last_word) begin
        phase_d = PH_HEADER;
        left_d  = '0;
        type_d  = '0;
        cnt_d   = '0;
        pad_d   = 1'b0;
        len_d   = '0;
        seen_d  = '0;
        stop_d  = ST_OK;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HEADER;
      left_q  <= '0;
      type_q  <= '0;
      cnt_q   <= '0;
      pad_q   <= 1'b0;
      len_q   <= '0;
      seen_q  <= '0;
      stop_q  <= ST_OK;
    end else begin
      phase_q <= phase_d;
      left_q  <= left_d;
      type_q  <= type_d;
      cnt_q   <= cnt_d;
      pad_q   <= pad_d;
      len_q   <= len_d;
      seen_q  <= seen_d;
      stop_q  <= stop_d;
    end
  end

  // a packet in progress never coexists with a failed header
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_BODY |-> stop_q == ST_OK)
    else $error("body phase with nonzero stop status");

  // skipping only follows a header check failure
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_SKIP |-> stop_q == ST_BAD_VER || stop_q == ST_BAD_TYPE)
    else $error("skip phase without bad header status");

  // in body phase there is always at least one word left
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_BODY |-> left_q != '0)
    else $error("body phase with no words left");

endmodule

FILE: rtl/rcpw_result_queue.sv
// ----------------------------------------------------------------------------
// Walker result queue
// Four-entry queue taking up to two results per cycle, releasing one.
// ----------------------------------------------------------------------------
module rcpw_result_queue
  import rcpw_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  rcpw_push_t push_i,
  output logic       room_o,
  rcpw_out_if.source out_o
);

  rcpw_result_t     mem_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0] cnt_q, cnt_d;
  logic             pop;
  rcpw_result_t     head;

  assign head   = mem_q[rd_ptr_q];
  assign pop    = out_o.valid & out_o.ready;
  assign room_o = cnt_q <= QCntW'(QDepth - 2);

  assign out_o.valid        = cnt_q != '0;
  assign out_o.kind         = head.kind;
  assign out_o.packet_type  = head.packet_type;
  assign out_o.item_count   = head.item_count;
  assign out_o.padding      = head.padding;
  assign out_o.length_words = head.length_words;
  assign out_o.packet_total = head.packet_total;
  assign out_o.status       = head.status;
  assign out_o.last_result  = head.last_result;

  always_comb begin
    wr_ptr_d = wr_ptr_q + QPtrW'(push_i.num);
    rd_ptr_d = rd_ptr_q + QPtrW'(pop);
    cnt_d    = cnt_q + QCntW'(push_i.num) - QCntW'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_i.num != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.first;
    end
    if (push_i.num == 2'd2) begin
      mem_q[wr_ptr_q + QPtrW'(1)] <= push_i.second;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QCntW'(QDepth))
    else $error("result queue overflow");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.num != 2'd0 |-> (QCntW'(push_i.num) + cnt_q) <= QCntW'(QDepth))
    else $error("push into full result queue");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.num != 2'd3)
    else $error("invalid push count");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == '0 |-> wr_ptr_q == rd_ptr_q)
    else $error("queue pointers disagree with empty count");

endmodule

FILE: rtl/rtcp_compound_packet_walker_core.sv
// ----------------------------------------------------------------------------
// RTCP compound packet walker core
// Walks a compound RTCP buffer word by word and reports packets and status.
// ----------------------------------------------------------------------------
// Takes one 32-bit word per cycle. Each word is checked and tracked as it is
// accepted; its results (a packet record, a buffer summary, or both when
// the last word also closes a packet) land in a four-entry result queue and
// are presented on the output in order. The input stalls only
// while fewer than two queue slots are free, so with the output ready the
// sustained rate is one word per clock.
module rtcp_compound_packet_walker_core
  import rcpw_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  rcpw_in_if.sink    in_i,
  rcpw_out_if.source out_o
);

  rcpw_push_t push;
  logic       room;

  rcpw_walker u_walker (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .room_i (room),
    .in_i   (in_i),
    .push_o (push)
  );

  rcpw_result_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .room_o (room),
    .out_o  (out_o)
  );

endmodule
